@@ rtl/fmed_pkg.sv @@
// Shared constants for the sliding-window median FIFO.
// Used by fifo_window_running_median, fmed_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package fmed_pkg;

    localparam int DEPTH    = 64;
    localparam int ADDR_W   = 6;
    localparam int CNT_W    = 7;
    localparam int SAMPLE_W = 16;

    // Operation codes carried on the input tuser bit.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_REJ_FULL  = 2'd1;
    localparam logic [1:0] ST_REJ_EMPTY = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_CAPACITY = 1'b0;

    // Clamp the written capacity into 1..DEPTH.
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] res;
        if (cap == '0) begin
            res = CNT_W'(1);
        end else if (cap > CNT_W'(DEPTH)) begin
            res = CNT_W'(DEPTH);
        end else begin
            res = cap;
        end
        return res;
    endfunction

endpackage

@@ rtl/fmed_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used by fifo_window_running_median for both sample stores.
`timescale 1ns / 1ps

module fmed_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fifo_window_running_median.sv @@
// Sliding-window median FIFO: an arrival-order ring and a sorted copy in two RAMs.
// An enqueue moves each larger sorted entry up one place and writes the sample in the hole; a
// dequeue reads the oldest sample, removes one copy of it from the sorted store and shifts the
// rest down; a rejection only reads the medians. One word is in work at a time; a new word is
// taken once the result is registered, so no word is taken before the last one is through.
// Reset (synchronous, active low) empties the queue and sets capacity to 64; RAMs are not cleared.
// Depends on fmed_pkg and fmed_ram.
`timescale 1ns / 1ps

module fifo_window_running_median (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_value
    input  logic        s_axis_tuser,   // [0] op
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] dequeued_value, [22:16] element_count, [29:23] free_slots,
    // [45:30] lower_median, [61:46] upper_median, [63:62] zero
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // [0] median_valid, [2:1] status
);

    localparam int AW = fmed_pkg::ADDR_W;
    localparam int CW = fmed_pkg::CNT_W;
    localparam int SW = fmed_pkg::SAMPLE_W;

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_CMP = 4'd1;
    localparam logic [3:0] S_INS_KEY = 4'd2;
    localparam logic [3:0] S_DQ_RD   = 4'd3;
    localparam logic [3:0] S_SR_CMP  = 4'd4;
    localparam logic [3:0] S_SH_RD   = 4'd5;
    localparam logic [3:0] S_SH_WR   = 4'd6;
    localparam logic [3:0] S_UPD     = 4'd7;
    localparam logic [3:0] S_MED_LO  = 4'd8;
    localparam logic [3:0] S_MED_HI  = 4'd9;
    localparam logic [3:0] S_MED_GET = 4'd10;
    localparam logic [3:0] S_OUT     = 4'd11;

    logic [3:0]    r_state, n_state;
    logic          r_op, n_op;
    logic [SW-1:0] r_key, n_key;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_rslot, n_rslot;
    logic [CW-1:0] r_cap;
    logic [1:0]    r_status, n_status;
    logic [SW-1:0] r_deq, n_deq;
    logic [SW-1:0] r_lo, n_lo;
    logic [SW-1:0] r_hi, n_hi;
    logic          r_ovalid;
    logic [63:0]   r_odata;
    logic [2:0]    r_ouser;

    logic          arr_we;
    logic [SW-1:0] arr_rdata;
    logic          srt_we;
    logic [AW-1:0] srt_waddr, srt_raddr;
    logic [SW-1:0] srt_wdata, srt_rdata;

    logic          in_acc;
    logic          out_load;
    logic [CW-1:0] cap_eff;
    logic [CW-1:0] free_now;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] cnt_dec;

    assign cap_eff  = fmed_pkg::eff_cap(r_cap);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);
    assign idx_inc  = r_idx + CW'(1);
    assign cnt_dec  = r_count - CW'(1);
    assign free_now = (r_count < cap_eff) ? (cap_eff - r_count) : '0;

    // Arrival ring: written on an accepted enqueue, read at the oldest slot.
    assign arr_we = in_acc && (s_axis_tuser == fmed_pkg::OP_ENQ) && (r_count < cap_eff);

    fmed_ram #(.DEPTH(fmed_pkg::DEPTH), .WIDTH(SW)) u_arr_ram (
        .i_clk   (i_clk),
        .i_we    (arr_we),
        .i_waddr (r_rslot + r_count[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_rslot),
        .o_rdata (arr_rdata)
    );

    fmed_ram #(.DEPTH(fmed_pkg::DEPTH), .WIDTH(SW)) u_srt_ram (
        .i_clk   (i_clk),
        .i_we    (srt_we),
        .i_waddr (srt_waddr),
        .i_wdata (srt_wdata),
        .i_raddr (srt_raddr),
        .o_rdata (srt_rdata)
    );

    // Sequencer: walks the sorted store to insert or remove one sample, then reads the two medians.
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_idx     = r_idx;
        n_count   = r_count;
        n_rslot   = r_rslot;
        n_status  = r_status;
        n_deq     = r_deq;
        n_lo      = r_lo;
        n_hi      = r_hi;
        srt_we    = 1'b0;
        srt_waddr = r_idx[AW-1:0];
        srt_wdata = r_key;
        srt_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op     = s_axis_tuser;
                    n_key    = s_axis_tdata;
                    n_deq    = '0;
                    n_status = fmed_pkg::ST_DONE;
                    if (s_axis_tuser == fmed_pkg::OP_ENQ) begin
                        if (r_count >= cap_eff) begin
                            n_status = fmed_pkg::ST_REJ_FULL;
                            n_state  = S_MED_LO;
                        end else if (r_count == '0) begin
                            srt_we    = 1'b1;
                            srt_waddr = '0;
                            srt_wdata = s_axis_tdata;
                            n_state   = S_UPD;
                        end else begin
                            srt_raddr = cnt_dec[AW-1:0];
                            n_idx     = r_count;
                            n_state   = S_INS_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = fmed_pkg::ST_REJ_EMPTY;
                            n_state  = S_MED_LO;
                        end else begin
                            n_state = S_DQ_RD;
                        end
                    end
                end
            end
            S_INS_CMP: begin
                // Read data is the entry just below the hole at r_idx.
                srt_we = 1'b1;
                if ($signed(srt_rdata) > $signed(r_key)) begin
                    srt_wdata = srt_rdata;
                    n_idx     = r_idx - CW'(1);
                    if (r_idx == CW'(1)) begin
                        n_state = S_INS_KEY;
                    end else begin
                        srt_raddr = AW'(r_idx - CW'(2));
                    end
                end else begin
                    n_state = S_UPD;
                end
            end
            S_INS_KEY: begin
                srt_we  = 1'b1;
                n_state = S_UPD;
            end
            S_DQ_RD: begin
                n_key     = arr_rdata;
                n_deq     = arr_rdata;
                n_idx     = '0;
                srt_raddr = '0;
                n_state   = S_SR_CMP;
            end
            S_SR_CMP: begin
                // Search for one copy of the removed value.
                if (srt_rdata == r_key) begin
                    n_state = S_SH_RD;
                end else if (idx_inc >= r_count) begin
                    n_state = S_UPD;
                end else begin
                    srt_raddr = idx_inc[AW-1:0];
                    n_idx     = idx_inc;
                end
            end
            S_SH_RD: begin
                if (idx_inc < r_count) begin
                    srt_raddr = idx_inc[AW-1:0];
                    n_state   = S_SH_WR;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_SH_WR: begin
                srt_we    = 1'b1;
                srt_wdata = srt_rdata;
                n_idx     = idx_inc;
                n_state   = S_SH_RD;
            end
            S_UPD: begin
                if (r_op == fmed_pkg::OP_ENQ) begin
                    n_count = r_count + CW'(1);
                end else begin
                    n_count = cnt_dec;
                    n_rslot = r_rslot + AW'(1);
                end
                n_state = S_MED_LO;
            end
            S_MED_LO: begin
                if (r_count == '0) begin
                    n_lo    = '0;
                    n_hi    = '0;
                    n_state = S_OUT;
                end else begin
                    srt_raddr = cnt_dec[AW:1];
                    n_state   = S_MED_HI;
                end
            end
            S_MED_HI: begin
                srt_raddr = r_count[AW:1];
                n_lo      = srt_rdata;
                n_state   = S_MED_GET;
            end
            S_MED_GET: begin
                n_hi    = srt_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rslot  <= '0;
            r_cap    <= CW'(fmed_pkg::DEPTH);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rslot <= n_rslot;
            if (psel && penable && pwrite && pready && (paddr[2] == fmed_pkg::REG_CAPACITY)) begin
                r_cap <= pwdata[CW-1:0];
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working and result payload.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_deq    <= n_deq;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        if (out_load) begin
            r_odata <= {2'b00, r_hi, r_lo, free_now, r_count, r_deq};
            r_ouser <= {r_status, (r_count != '0)};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == fmed_pkg::REG_CAPACITY) ? {25'd0, r_cap} : 32'd0;

    // The count never exceeds the store depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(fmed_pkg::DEPTH))
        else $error("element count beyond depth");

    // The count moves by at most one per step.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1))))
        else $error("element count jumped");

    // A full rejection always reports no free slot.
    a_full_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ouser[2:1] == fmed_pkg::ST_REJ_FULL)) |-> (r_odata[29:23] == '0))
        else $error("full rejection with free slots");

    // The count only changes while an item is being worked.
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_count == $past(r_count)))
        else $error("count changed while idle");

endmodule

@@ dv/fmed_checker.sv @@
// Result checker for the sliding-window median FIFO: watches both streams and the register port.
// Keeps its own queue and sorted copy to predict each result word; depends on fmed_pkg.
`timescale 1ns / 1ps

module fmed_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);

    typedef struct packed {
        logic [63:0] data;
        logic [2:0]  user;
    } t_result_word;

    logic signed [15:0]         fifo_vals[$];
    logic signed [15:0]         sorted_vals[$];
    logic [fmed_pkg::CNT_W-1:0] cap_reg;
    t_result_word               pending_results[$];

    assign o_pending = pending_results.size();

    // Apply one input word to the model and build the expected result.
    function automatic t_result_word predict_word(logic op, logic signed [15:0] val);
        t_result_word               r;
        logic [fmed_pkg::CNT_W-1:0] cap;
        logic signed [15:0]         deq;
        logic [1:0]                 st;
        logic [fmed_pkg::CNT_W-1:0] cnt;
        logic [fmed_pkg::CNT_W-1:0] fr;
        logic signed [15:0]         lo;
        logic signed [15:0]         hi;
        int                         i;
        cap = (cap_reg == 0) ? fmed_pkg::CNT_W'(1) :
              (cap_reg > fmed_pkg::DEPTH ? fmed_pkg::CNT_W'(fmed_pkg::DEPTH) : cap_reg);
        deq = '0;
        st  = fmed_pkg::ST_DONE;
        if (op == fmed_pkg::OP_ENQ) begin
            if (fifo_vals.size() >= cap) begin
                st = fmed_pkg::ST_REJ_FULL;
            end else begin
                fifo_vals.push_back(val);
                i = 0;
                while (i < sorted_vals.size() && sorted_vals[i] <= val) i++;
                sorted_vals.insert(i, val);
            end
        end else begin
            if (fifo_vals.size() == 0) begin
                st = fmed_pkg::ST_REJ_EMPTY;
            end else begin
                deq = fifo_vals.pop_front();
                i = 0;
                while (sorted_vals[i] != deq) i++;
                sorted_vals.delete(i);
            end
        end
        cnt = fmed_pkg::CNT_W'(fifo_vals.size());
        fr  = (cnt < cap) ? cap - cnt : '0;
        lo  = '0;
        hi  = '0;
        if (cnt != 0) begin
            lo = sorted_vals[(cnt - 1) / 2];
            hi = sorted_vals[cnt / 2];
        end
        r.data = {2'b00, hi, lo, fr, cnt, deq};
        r.user = {st, (cnt != 0)};
        return r;
    endfunction

    // Track register writes and input words, then compare each result word.
    always @(posedge i_clk) begin
        t_result_word exp_w;
        if (!i_rst_n) begin
            cap_reg = fmed_pkg::CNT_W'(fmed_pkg::DEPTH);
            fifo_vals.delete();
            sorted_vals.delete();
            pending_results.delete();
            o_fail_count   <= 0;
            o_results_seen <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == fmed_pkg::REG_CAPACITY)
                cap_reg = pwdata[fmed_pkg::CNT_W-1:0];
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(predict_word(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                o_results_seen <= o_results_seen + 1;
                if (pending_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result word %h/%h", m_axis_tdata,
                                 m_axis_tuser);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = pending_results.pop_front();
                    if (exp_w.data !== m_axis_tdata || exp_w.user !== m_axis_tuser) begin
                        if (o_fail_count < 10)
                            $display("ERROR: result mismatch exp %h/%h got %h/%h",
                                     exp_w.data, exp_w.user, m_axis_tdata, m_axis_tuser);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ dv/tb_fifo_window_running_median.sv @@
// Testbench top for the sliding-window median FIFO: drives stimulus and gives the verdict.
// Depends on fmed_pkg, the block under test and fmed_checker.
`timescale 1ns / 1ps

module tb_fifo_window_running_median;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    int fail_count;
    int pending;
    int results_seen;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int words_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fifo_window_running_median dut (.*);

    fmed_checker u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    // Receiver: random stalls, or a long counted hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Write the capacity register with a setup phase and then an access phase.
    task automatic write_capacity(input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {fmed_pkg::REG_CAPACITY, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one word and hold it until the block accepts it; valid drops only while idling.
    task automatic send_word(input logic op, input logic [15:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= val;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    // Stop offering, wait for every expected result, then let the block settle.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Random mix of enqueues and dequeues (about 40 percent dequeues), with random values.
    task automatic random_phase(input int n, input int idle_pct, input int stall_pct);
        logic [15:0] v;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3))
                0: v = 16'($urandom_range(7) - 4);
                1: v = $urandom_range(1) ? 16'h7fff : 16'h8000;
                default: v = 16'($urandom);
            endcase
            send_word(($urandom_range(99) < 40) ? fmed_pkg::OP_DEQ : fmed_pkg::OP_ENQ, v);
        end
        drain();
    endtask

    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dequeue, extremes, equal values, full reject at capacity 1.
        recv_stall_pct = 0;
        send_word(fmed_pkg::OP_DEQ, 16'h1234);
        send_word(fmed_pkg::OP_ENQ, 16'h7fff);
        send_word(fmed_pkg::OP_ENQ, 16'h8000);
        send_word(fmed_pkg::OP_ENQ, 16'h0000);
        send_word(fmed_pkg::OP_ENQ, 16'h0000);
        send_word(fmed_pkg::OP_ENQ, 16'hffff);
        send_word(fmed_pkg::OP_DEQ, 16'h0);
        send_word(fmed_pkg::OP_DEQ, 16'h0);
        send_word(fmed_pkg::OP_DEQ, 16'h0);
        send_word(fmed_pkg::OP_DEQ, 16'h0);
        send_word(fmed_pkg::OP_DEQ, 16'h0);
        send_word(fmed_pkg::OP_DEQ, 16'h0);
        drain();
        write_capacity(32'd1);
        send_word(fmed_pkg::OP_ENQ, 16'h5555);
        send_word(fmed_pkg::OP_ENQ, 16'haaaa);
        send_word(fmed_pkg::OP_DEQ, 16'h0);
        drain();

        // Out-of-range capacities, then capacity lowered below the count.
        write_capacity(32'd0);
        send_word(fmed_pkg::OP_ENQ, 16'h0001);
        send_word(fmed_pkg::OP_ENQ, 16'h0002);
        drain();
        write_capacity(32'h7f);
        for (int k = 0; k < 6; k++) send_word(fmed_pkg::OP_ENQ, 16'(k * 3 - 7));
        drain();
        write_capacity(32'd3);
        send_word(fmed_pkg::OP_ENQ, 16'h0009);
        send_word(fmed_pkg::OP_DEQ, 16'h0);
        send_word(fmed_pkg::OP_DEQ, 16'h0);
        send_word(fmed_pkg::OP_DEQ, 16'h0);
        send_word(fmed_pkg::OP_DEQ, 16'h0);
        send_word(fmed_pkg::OP_ENQ, 16'h0010);
        drain();

        // Random phases across capacities and idling patterns.
        write_capacity(32'd64);
        random_phase(250, 0, 0);
        write_capacity(32'd5);
        random_phase(150, 73, 0);
        write_capacity(32'd64);
        hold_cycles = 400;
        random_phase(150, 0, 73);
        write_capacity(32'd17);
        random_phase(150, 6, 6);
        write_capacity(32'd2);
        random_phase(100, 30, 30);

        $display("Covered %0d input words, %0d results, capacities 0..127 incl. extremes.",
                 words_sent, results_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ fifo_window_running_median.f @@
rtl/fmed_pkg.sv
rtl/fmed_ram.sv
rtl/fifo_window_running_median.sv
dv/fmed_checker.sv
dv/tb_fifo_window_running_median.sv
